[src/lcdx_pkg.sv]
package lcdx_pkg;

   localparam logic [1:0] REQ_INIT   = 2'd0;
   localparam logic [1:0] REQ_CLEAR  = 2'd1;
   localparam logic [1:0] REQ_CURSOR = 2'd2;
   localparam logic [1:0] REQ_CHAR   = 2'd3;

   localparam logic [7:0] CMD_CLEAR     = 8'h01;
   localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
   localparam logic [2:0] CLEAR_EXTRA_MS = 3'd2;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned STEP_W      = 5;

   localparam logic [STEP_W-1:0] INIT_LAST_STEP = 5'd23;
   localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 5'd3;
   localparam logic [5:0]        INIT_WAIT_MS   = 6'd50;

   // One queued command: either the whole init program or a single LCD byte.
   typedef struct packed {
      logic       is_init;
      logic [7:0] value;
      logic       rs;
      logic [2:0] extra_ms;
   } cmd_type;

   // High nibbles of the init program: wake 3,3,3,2 then 0x28, 0x0C, 0x06, 0x01.
   function automatic logic [3:0] init_nibble(input logic [3:0] idx);
      logic [3:0] nib;
      case (idx)
         4'd0, 4'd1, 4'd2: nib = 4'h3;
         4'd3, 4'd4:       nib = 4'h2;
         4'd5:             nib = 4'h8;
         4'd7:             nib = 4'hC;
         4'd9:             nib = 4'h6;
         4'd11:            nib = 4'h1;
         default:          nib = 4'h0;
      endcase
      return nib;
   endfunction

   // Extra wait after the enable-low byte of each init nibble.
   function automatic logic [2:0] init_extra(input logic [3:0] idx);
      logic [2:0] ms;
      case (idx) inside
         4'd0:         ms = 3'd5;
         4'd1, 4'd2:   ms = 3'd1;
         4'd11:        ms = CLEAR_EXTRA_MS;
         default:      ms = 3'd0;
      endcase
      return ms;
   endfunction

endpackage

[src/lcdx_front.sv]
module lcdx_front (
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_type,
   input  logic [7:0]       req_char_code,
   input  logic [5:0]       req_col,
   input  logic             req_row,
   output logic             push_valid,
   input  logic             push_ready,
   output lcdx_pkg::cmd_type push_cmd
);
   import lcdx_pkg::*;

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

   // Classify the request into one queued command.
   always_comb begin
      push_cmd = '0;
      case (req_type)
         REQ_INIT: begin
            push_cmd.is_init = 1'b1;
         end
         REQ_CLEAR: begin
            push_cmd.value    = CMD_CLEAR;
            push_cmd.extra_ms = CLEAR_EXTRA_MS;
         end
         REQ_CURSOR: begin
            // row 1 adds 0x40: col never exceeds 6 bits, so just concatenate
            push_cmd.value = CMD_SET_DDRAM | {1'b0, req_row, req_col};
         end
         default: begin
            push_cmd.value = req_char_code;
            push_cmd.rs    = 1'b1;
         end
      endcase
   end

endmodule

[src/lcdx_queue.sv]
module lcdx_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  lcdx_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop,
   output lcdx_pkg::cmd_type pop_cmd
);
   import lcdx_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[src/lcdx_back.sv]
module lcdx_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  lcdx_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_expander_byte,
   output logic [5:0]       rsp_delay_before_ms,
   output logic [2:0]       rsp_delay_after_ms,
   output logic             rsp_last
);
   import lcdx_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   logic              valid_ff, valid_in;
   logic [7:0]        byte_ff, byte_in;
   logic [5:0]        before_ff, before_in;
   logic [2:0]        after_ff, after_in;
   logic              last_ff, last_in;

   logic [3:0] nib_idx;
   logic       enable;
   logic [3:0] nibble;
   logic [2:0] extra_ms;
   logic       advance;

   assign nib_idx = step_ff[STEP_W-1:1];
   assign enable  = ~step_ff[0];
   assign advance = cmd_valid && (!valid_ff || rsp_ready);
   assign cmd_pop = advance && last_in;

   // Build the expander byte for the current step of the head command.
   always_comb begin
      if (cmd.is_init) begin
         nibble    = init_nibble(nib_idx);
         extra_ms  = init_extra(nib_idx);
         last_in   = (step_ff == INIT_LAST_STEP);
         before_in = (step_ff == '0) ? INIT_WAIT_MS : 6'd0;
      end else begin
         nibble    = nib_idx[0] ? cmd.value[3:0] : cmd.value[7:4];
         extra_ms  = (step_ff == BYTE_LAST_STEP) ? cmd.extra_ms : 3'd0;
         last_in   = (step_ff == BYTE_LAST_STEP);
         before_in = 6'd0;
      end
      byte_in  = {nibble, 1'b1, enable, 1'b0, cmd.rs};
      after_in = enable ? 3'd1 : 3'd1 + extra_ms;
      step_in  = last_in ? '0 : step_ff + 1'b1;
      valid_in = advance ? 1'b1 : (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (advance) begin
            step_ff <= step_in;
         end
      end
   end

   // Hold the result until transfer; load the next one in the same cycle.
   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff   <= byte_in;
         before_ff <= before_in;
         after_ff  <= after_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_expander_byte   = byte_ff;
   assign rsp_delay_before_ms = before_ff;
   assign rsp_delay_after_ms  = after_ff;
   assign rsp_last            = last_ff;

endmodule

[src/char_lcd_expander_sequencer.sv]
// Turns LCD requests (init, clear, set cursor, write character) into the byte
// stream for an 8-bit I/O expander driving a character LCD in 4-bit mode. Each
// result is one expander byte with the waits in ms before and after it, and
// last marks the final byte of a request. Clear, set cursor and write character
// give 4 results each; init gives 24. Results leave at one per clock while
// rsp_ready is high and a command is queued. A two-entry command queue lets
// up to two further requests be taken while a result waits for transfer.
module char_lcd_expander_sequencer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [7:0] req_char_code,
   input  logic [5:0] req_col,
   input  logic       req_row,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_expander_byte,
   output logic [5:0] rsp_delay_before_ms,
   output logic [2:0] rsp_delay_after_ms,
   output logic       rsp_last
);
   import lcdx_pkg::*;

   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    head_valid, head_pop;
   cmd_type head_cmd;

   lcdx_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_char_code (req_char_code),
      .req_col       (req_col),
      .req_row       (req_row),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_cmd      (push_cmd)
   );

   lcdx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (head_valid),
      .pop        (head_pop),
      .pop_cmd    (head_cmd)
   );

   lcdx_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cmd_valid           (head_valid),
      .cmd                 (head_cmd),
      .cmd_pop             (head_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_expander_byte   (rsp_expander_byte),
      .rsp_delay_before_ms (rsp_delay_before_ms),
      .rsp_delay_after_ms  (rsp_delay_after_ms),
      .rsp_last            (rsp_last)
   );

endmodule

[src/lcdx_checker.sv]
module lcdx_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_expander_byte,
   input logic [5:0] rsp_delay_before_ms,
   input logic [2:0] rsp_delay_after_ms,
   input logic       rsp_last
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_expander_byte)
         && $stable(rsp_last))
      else $error("result changed while stalled");

   // Enable-high byte opens a nibble: never last, short wait after.
   a_enable_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_expander_byte[2] |-> !rsp_last && rsp_delay_after_ms == 3'd1)
      else $error("enable-high byte ends a request or waits long");

   // Backlight on and write mode on every byte.
   a_fixed_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_expander_byte[3] && !rsp_expander_byte[1])
      else $error("backlight off or read selected");

   // Only the first init byte waits before, and always 50 ms.
   a_power_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_delay_before_ms != 6'd0 |->
         rsp_delay_before_ms == 6'd50 && rsp_expander_byte[2]
         && rsp_expander_byte[7:4] == 4'h3)
      else $error("unexpected wait before byte");

   // Nothing is offered right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind char_lcd_expander_sequencer lcdx_checker u_lcdx_checker (.*);

[sim/char_lcd_expander_sequencer_tb.sv]
module char_lcd_expander_sequencer_tb;
   import lcdx_pkg::*;

   localparam int unsigned CYCLE_LIMIT      = 400000;
   localparam int unsigned RANDOM_REQS      = 450;
   localparam int unsigned LONG_HOLD_CYCLES = 400;
   localparam int unsigned LONG_HOLD_AFTER  = 60;
   localparam int unsigned DRAIN_CYCLES     = 40;
   localparam int unsigned PRINT_CAP        = 50;

   // Expander byte layout: D7..D4, backlight, enable, read/write, register select.
   localparam logic [7:0] XB_EN      = 8'h04;
   localparam logic [7:0] XB_BL      = 8'h08;
   localparam logic [7:0] NIB_MASK   = 8'hF0;
   localparam logic [7:0] ROW1_BASE  = 8'h40;
   localparam logic [7:0] WAKE_8BIT  = 8'h30;
   localparam logic [7:0] WAKE_4BIT  = 8'h20;
   localparam logic [7:0] LCD_FUNC   = 8'h28;
   localparam logic [7:0] LCD_DISP   = 8'h0C;
   localparam logic [7:0] LCD_ENTRY  = 8'h06;
   localparam logic [5:0] POWER_UP_MS = 6'd50;

   typedef struct packed {
      logic [7:0] xbyte;
      logic [5:0] pre_ms;
      logic [2:0] post_ms;
      logic       last;
   } lcd_xfer_t;

   class lcd_stream_board;
      lcd_xfer_t   expected_bytes[$];
      int unsigned mismatches;

      task report(string msg);
         if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
         mismatches++;
      endtask

      // One nibble: enable-high byte, then enable-low byte with the extra wait.
      function void push_nibble(logic [7:0] hi4, logic rs, logic [5:0] pre, logic [2:0] extra);
         logic [7:0] d;
         lcd_xfer_t  x;
         d = (hi4 & NIB_MASK) | {7'd0, rs} | XB_BL;
         x.xbyte = d | XB_EN;
         x.pre_ms = pre;
         x.post_ms = 3'd1;
         x.last = 1'b0;
         expected_bytes.push_back(x);
         x.xbyte = d & ~XB_EN;
         x.pre_ms = 6'd0;
         x.post_ms = 3'd1 + extra;
         expected_bytes.push_back(x);
      endfunction

      function void push_lcd_byte(logic [7:0] value, logic rs, logic [2:0] extra);
         push_nibble(value & NIB_MASK, rs, 6'd0, 3'd0);
         push_nibble({value[3:0], 4'h0}, rs, 6'd0, extra);
      endfunction

      function void note_request(logic [1:0] kind, logic [7:0] ch, logic [5:0] col, logic row);
         logic [7:0] addr;
         addr = {2'b00, col} + (row ? ROW1_BASE : 8'h00);
         case (kind)
            REQ_INIT: begin
               push_nibble(WAKE_8BIT, 1'b0, POWER_UP_MS, 3'd5);
               push_nibble(WAKE_8BIT, 1'b0, 6'd0, 3'd1);
               push_nibble(WAKE_8BIT, 1'b0, 6'd0, 3'd1);
               push_nibble(WAKE_4BIT, 1'b0, 6'd0, 3'd0);
               push_lcd_byte(LCD_FUNC, 1'b0, 3'd0);
               push_lcd_byte(LCD_DISP, 1'b0, 3'd0);
               push_lcd_byte(LCD_ENTRY, 1'b0, 3'd0);
               push_lcd_byte(CMD_CLEAR, 1'b0, CLEAR_EXTRA_MS);
            end
            REQ_CLEAR:  push_lcd_byte(CMD_CLEAR, 1'b0, CLEAR_EXTRA_MS);
            REQ_CURSOR: push_lcd_byte(CMD_SET_DDRAM | addr, 1'b0, 3'd0);
            default:    push_lcd_byte(ch, 1'b1, 3'd0);
         endcase
         expected_bytes[expected_bytes.size() - 1].last = 1'b1;
      endfunction

      task check_byte(logic [7:0] xb, logic [5:0] pre, logic [2:0] post, logic lst);
         lcd_xfer_t e;
         if (expected_bytes.size() == 0) begin
            report($sformatf("unexpected byte %h", xb));
            return;
         end
         e = expected_bytes.pop_front();
         if (xb !== e.xbyte)
            report($sformatf("expander_byte %h, want %h", xb, e.xbyte));
         if (pre !== e.pre_ms)
            report($sformatf("delay_before_ms %0d, want %0d", pre, e.pre_ms));
         if (post !== e.post_ms)
            report($sformatf("delay_after_ms %0d, want %0d", post, e.post_ms));
         if (lst !== e.last)
            report($sformatf("last %b, want %b (byte %h)", lst, e.last, e.xbyte));
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_type = REQ_INIT;
   logic [7:0] req_char_code = 8'd0;
   logic [5:0] req_col = 6'd0;
   logic       req_row = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_expander_byte;
   logic [5:0] rsp_delay_before_ms;
   logic [2:0] rsp_delay_after_ms;
   logic       rsp_last;

   lcd_stream_board board = new();
   int unsigned     reqs_taken = 0;
   int unsigned     cycles = 0;

   char_lcd_expander_sequencer i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_char_code      (req_char_code),
      .req_col            (req_col),
      .req_row            (req_row),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_expander_byte  (rsp_expander_byte),
      .rsp_delay_before_ms(rsp_delay_before_ms),
      .rsp_delay_after_ms (rsp_delay_after_ms),
      .rsp_last           (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("char_lcd_expander_sequencer_tb: done, errors");
         $finish;
      end
   end

   // Sample both channels at the edge: note the request first, then check the result.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            board.note_request(req_type, req_char_code, req_col, req_row);
            reqs_taken++;
         end
         if (rsp_valid && rsp_ready)
            board.check_byte(rsp_expander_byte, rsp_delay_before_ms,
                             rsp_delay_after_ms, rsp_last);
      end
   end

   // Mostly short gaps, a few long ones.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 60);
   endfunction

   // Called at a clock edge; returns at the edge where the request transfers.
   task send_req(logic [1:0] kind, logic [7:0] ch, logic [5:0] col, logic row,
                 int unsigned gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_char_code <= ch;
      req_col <= col;
      req_row <= row;
      do @(posedge clock); while (!req_ready);
   endtask

   task send_random(int unsigned gap);
      int unsigned r;
      logic [1:0]  kind;
      r = $urandom_range(0, 99);
      if (r < 60)
         kind = REQ_CHAR;
      else if (r < 80)
         kind = REQ_CURSOR;
      else if (r < 92)
         kind = REQ_CLEAR;
      else
         kind = REQ_INIT;
      send_req(kind, 8'($urandom), 6'($urandom), 1'($urandom), gap);
   endtask

   // Receiver: random ready runs and stalls, plus one long hold-off to fill the block.
   initial begin
      bit          long_hold_done;
      int unsigned run_len;
      int unsigned stall;
      long_hold_done = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!long_hold_done && reqs_taken >= LONG_HOLD_AFTER) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_done = 1'b1;
         end else begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 12);
            rsp_ready <= 1'b1;
            repeat (run_len) @(posedge clock);
            stall = pick_gap();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: every request kind, field extremes, row 1 offset, back-to-back init.
      send_req(REQ_INIT,   8'h00, 6'd0,  1'b0, 0);
      send_req(REQ_CLEAR,  8'hFF, 6'd63, 1'b1, pick_gap());
      send_req(REQ_CURSOR, 8'h00, 6'd0,  1'b0, pick_gap());
      send_req(REQ_CURSOR, 8'h00, 6'd63, 1'b0, pick_gap());
      send_req(REQ_CURSOR, 8'hFF, 6'd0,  1'b1, 0);
      send_req(REQ_CURSOR, 8'h00, 6'd63, 1'b1, 0);
      send_req(REQ_CHAR,   8'h00, 6'd0,  1'b0, pick_gap());
      send_req(REQ_CHAR,   8'hFF, 6'd63, 1'b1, 0);
      send_req(REQ_CHAR,   8'hA5, 6'd21, 1'b0, 0);
      send_req(REQ_CHAR,   8'h5A, 6'd42, 1'b1, pick_gap());
      send_req(REQ_CHAR,   8'h0F, 6'd0,  1'b1, 0);
      send_req(REQ_CHAR,   8'hF0, 6'd63, 1'b0, 0);
      send_req(REQ_INIT,   8'hFF, 6'd63, 1'b1, 0);
      send_req(REQ_INIT,   8'h5A, 6'd17, 1'b0, 0);
      send_req(REQ_CLEAR,  8'h00, 6'd0,  1'b0, 0);
      send_req(REQ_CURSOR, 8'h80, 6'd40, 1'b1, pick_gap());

      // Random: stretches of back-to-back requests between gapped ones.
      for (int unsigned i = 0; i < RANDOM_REQS; i++)
         send_random((i % 100 < 20) ? 0 : pick_gap());
      req_valid <= 1'b0;

      @(posedge clock);
      while (board.expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0)
         $display("char_lcd_expander_sequencer_tb: done, clean");
      else
         $display("char_lcd_expander_sequencer_tb: done, errors");
      $finish;
   end

endmodule
